// File: design/encoded_line_classifier_core_defines.svh
// Assertion macros used by the encoded line classifier core.
`ifndef ENCODED_LINE_CLASSIFIER_CORE_DEFINES_SVH
`define ENCODED_LINE_CLASSIFIER_CORE_DEFINES_SVH

// Check that cons holds whenever ante holds, sampled on clk, off during reset.
`define ELC_CHECK(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check that cond holds at every clock edge out of reset.
`define ELC_INVARIANT(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error(msg);

`endif

// File: design/elc_pkg.sv
// Shared types, constants and functions of the encoded line classifier.
package elc_pkg;

    localparam int CHUNK_BYTES_DEFAULT = 511;

    localparam int BYTE_W  = 8;
    localparam int VAL_W   = 32;
    localparam int LEN_W   = 12;
    localparam int TH_W    = 13;
    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 64;

    localparam logic [CFG_IDX_W-1:0] CFG_CHARSET_LOW  = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CHARSET_HIGH = 8'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LEN_THRESH   = 8'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_END_MARKER   = 8'd3;

    localparam logic [63:0]       CHARSET_LOW_RESET  = 64'h077F_3FFE_0000_2400;
    localparam logic [63:0]       CHARSET_HIGH_RESET = 64'h0007_3F7F_0F7F_7FFF;
    localparam logic [TH_W-1:0]   LEN_THRESH_RESET   = 13'd60;
    localparam logic [BYTE_W-1:0] END_MARKER_RESET   = 8'd58;

    localparam logic [1:0] VERDICT_DROP   = 2'd0;
    localparam logic [1:0] VERDICT_KEEP   = 2'd1;
    localparam logic [1:0] VERDICT_HEADER = 2'd2;

    localparam logic [BYTE_W-1:0] CH_NUL   = 8'd0;
    localparam logic [BYTE_W-1:0] CH_NL    = 8'd10;
    localparam logic [BYTE_W-1:0] CH_SPACE = 8'd32;
    localparam logic [BYTE_W-1:0] CH_TAB   = 8'd9;
    localparam logic [BYTE_W-1:0] CH_CR    = 8'd13;
    localparam logic [BYTE_W-1:0] CH_PLUS  = "+";
    localparam logic [BYTE_W-1:0] CH_MINUS = "-";
    localparam logic [BYTE_W-1:0] CH_ZERO  = "0";
    localparam logic [BYTE_W-1:0] CH_NINE  = "9";
    localparam logic [BYTE_W-1:0] CH_P     = "p";
    localparam logic [BYTE_W-1:0] CH_A     = "a";
    localparam logic [BYTE_W-1:0] CH_R     = "r";
    localparam logic [BYTE_W-1:0] CH_T     = "t";
    localparam logic [BYTE_W-1:0] CH_O     = "o";
    localparam logic [BYTE_W-1:0] CH_F     = "f";

    localparam logic [VAL_W-1:0] MAG_LIMIT = 32'h8000_0000;
    localparam logic [VAL_W-1:0] POS_MAX   = 32'h7FFF_FFFF;

    typedef struct packed {
        logic take;
        logic examine;
        logic close;
    } match_ctl_t;

    typedef struct packed {
        logic             found;
        logic [VAL_W-1:0] number;
        logic [VAL_W-1:0] total;
    } match_res_t;

    function automatic logic is_space(input logic [BYTE_W-1:0] c);
        return (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
    endfunction

    function automatic logic is_digit(input logic [BYTE_W-1:0] c);
        return (c >= CH_ZERO) && (c <= CH_NINE);
    endfunction

    function automatic logic [VAL_W-1:0] add_digit(input logic [VAL_W-1:0] mag,
                                                   input logic [BYTE_W-1:0] c);
        logic [VAL_W+3:0] v;
        logic [3:0]       d;
        d = 4'(c - CH_ZERO);
        v = {1'b0, mag, 3'b000} + {3'b000, mag, 1'b0} + (VAL_W+4)'(d);
        if (v > (VAL_W+4)'(MAG_LIMIT))
            return MAG_LIMIT;
        return v[VAL_W-1:0];
    endfunction

    function automatic logic [VAL_W-1:0] to_signed(input logic [VAL_W-1:0] mag,
                                                   input logic neg);
        if (neg)
            return VAL_W'(0) - mag;
        return (mag > POS_MAX) ? POS_MAX : mag;
    endfunction

endpackage

// File: design/elc_ifs.sv
// Channel interfaces of the encoded line classifier: text bytes, results, configuration.
interface elc_text_if;
    logic                            valid;
    logic                            ready;
    logic [elc_pkg::BYTE_W-1:0]      data_byte;
    logic                            input_end;

    modport source (output valid, output data_byte, output input_end, input ready);
    modport sink   (input valid, input data_byte, input input_end, output ready);
endinterface

interface elc_result_if;
    logic                            valid;
    logic                            ready;
    logic [1:0]                      verdict;
    logic signed [elc_pkg::VAL_W-1:0] part_number;
    logic signed [elc_pkg::VAL_W-1:0] part_total;
    logic [elc_pkg::LEN_W-1:0]       chunk_length;

    modport source (output valid, output verdict, output part_number, output part_total,
                    output chunk_length, input ready);
    modport sink   (input valid, input verdict, input part_number, input part_total,
                    input chunk_length, output ready);
endinterface

interface elc_cfg_if;
    logic                            valid;
    logic                            ready;
    logic [elc_pkg::CFG_IDX_W-1:0]   index;
    logic [elc_pkg::CFG_DATA_W-1:0]  data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// File: design/elc_matcher.sv
// Part header matcher: scans chunk bytes for "part N of M" and holds both numbers.
module elc_matcher
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  elc_pkg::match_ctl_t        ctl,
    input  logic [elc_pkg::BYTE_W-1:0] c,
    output elc_pkg::match_res_t        res
);

    typedef enum logic [3:0] {
        PH_IDLE, PH_P, PH_PA, PH_PAR, PH_PRE1, PH_SIGN1, PH_DIG1,
        PH_WSOF, PH_O, PH_PRE2, PH_SIGN2, PH_DIG2, PH_DONE
    } phase_t;

    phase_t                      phase_reg, phase_next;
    logic [elc_pkg::VAL_W-1:0]   first_reg, first_next;
    logic [elc_pkg::VAL_W-1:0]   second_reg, second_next;
    logic                        neg_reg, neg_next;
    logic                        found_reg, found_next;
    logic                        run;
    logic                        pre;

    assign run = ctl.take && ctl.examine && (!found_reg || phase_reg == PH_DIG2);
    assign pre = (phase_reg == PH_PRE1) || (phase_reg == PH_PRE2);

    always_comb
    begin
        phase_next  = phase_reg;
        first_next  = first_reg;
        second_next = second_reg;
        neg_next    = neg_reg;
        found_next  = found_reg;
        if (run)
        begin
            unique case (phase_reg)
                PH_IDLE:
                begin
                    if (c == elc_pkg::CH_P)
                        phase_next = PH_P;
                end
                PH_P, PH_PA, PH_PAR, PH_O:
                begin
                    if (phase_reg == PH_P && c == elc_pkg::CH_A)
                        phase_next = PH_PA;
                    else if (phase_reg == PH_PA && c == elc_pkg::CH_R)
                        phase_next = PH_PAR;
                    else if (phase_reg == PH_PAR && c == elc_pkg::CH_T)
                        phase_next = PH_PRE1;
                    else if (phase_reg == PH_O && c == elc_pkg::CH_F)
                        phase_next = PH_PRE2;
                    else
                    begin
                        phase_next  = (c == elc_pkg::CH_P) ? PH_P : PH_IDLE;
                        first_next  = '0;
                        second_next = '0;
                        neg_next    = 1'b0;
                    end
                end
                PH_PRE1, PH_PRE2, PH_SIGN1, PH_SIGN2:
                begin
                    if (pre && elc_pkg::is_space(c))
                        phase_next = phase_reg;
                    else if (pre && (c == elc_pkg::CH_PLUS || c == elc_pkg::CH_MINUS))
                    begin
                        neg_next   = (c == elc_pkg::CH_MINUS);
                        phase_next = (phase_reg == PH_PRE1) ? PH_SIGN1 : PH_SIGN2;
                    end
                    else if (!elc_pkg::is_digit(c))
                    begin
                        phase_next  = (c == elc_pkg::CH_P) ? PH_P : PH_IDLE;
                        first_next  = '0;
                        second_next = '0;
                        neg_next    = 1'b0;
                    end
                    else if (phase_reg == PH_PRE1 || phase_reg == PH_SIGN1)
                    begin
                        first_next = elc_pkg::add_digit('0, c);
                        phase_next = PH_DIG1;
                    end
                    else
                    begin
                        second_next = elc_pkg::add_digit('0, c);
                        phase_next  = PH_DIG2;
                        found_next  = 1'b1;
                    end
                end
                PH_DIG1:
                begin
                    if (elc_pkg::is_digit(c))
                        first_next = elc_pkg::add_digit(first_reg, c);
                    else if (elc_pkg::is_space(c) || c == elc_pkg::CH_O)
                    begin
                        first_next = elc_pkg::to_signed(first_reg, neg_reg);
                        neg_next   = 1'b0;
                        phase_next = (c == elc_pkg::CH_O) ? PH_O : PH_WSOF;
                    end
                    else
                    begin
                        phase_next  = (c == elc_pkg::CH_P) ? PH_P : PH_IDLE;
                        first_next  = '0;
                        second_next = '0;
                        neg_next    = 1'b0;
                    end
                end
                PH_WSOF:
                begin
                    if (c == elc_pkg::CH_O)
                        phase_next = PH_O;
                    else if (!elc_pkg::is_space(c))
                    begin
                        phase_next  = (c == elc_pkg::CH_P) ? PH_P : PH_IDLE;
                        first_next  = '0;
                        second_next = '0;
                        neg_next    = 1'b0;
                    end
                end
                PH_DIG2:
                begin
                    if (elc_pkg::is_digit(c))
                        second_next = elc_pkg::add_digit(second_reg, c);
                    else
                        phase_next = PH_DONE;
                end
                PH_DONE:
                begin
                    phase_next = PH_DONE;
                end
                default:
                begin
                    phase_next = PH_IDLE;
                end
            endcase
        end
    end

    assign res.found  = found_next;
    assign res.number = first_next;
    assign res.total  = elc_pkg::to_signed(second_next, neg_next);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_IDLE;
            first_reg  <= '0;
            second_reg <= '0;
            neg_reg    <= 1'b0;
            found_reg  <= 1'b0;
        end
        else if (ctl.take)
        begin
            if (ctl.close)
            begin
                phase_reg  <= PH_IDLE;
                first_reg  <= '0;
                second_reg <= '0;
                neg_reg    <= 1'b0;
                found_reg  <= 1'b0;
            end
            else
            begin
                phase_reg  <= phase_next;
                first_reg  <= first_next;
                second_reg <= second_next;
                neg_reg    <= neg_next;
                found_reg  <= found_next;
            end
        end
    end

endmodule

// File: design/encoded_line_classifier_core.sv
// Top level of the encoded line classifier: chunking, charset check and result register.
// Takes one text byte per cycle with no gaps of its own; text.ready falls only while a
// finished result waits in the output register and result.ready is low. The result of a
// chunk appears in the cycle after its closing byte is accepted (newline, CHUNK_BYTES
// bytes, or input_end), set by the single result register after the per-byte update.
// Configuration writes are always ready and take effect in the next cycle.
`include "encoded_line_classifier_core_defines.svh"

module encoded_line_classifier_core
#(
    parameter int CHUNK_BYTES = elc_pkg::CHUNK_BYTES_DEFAULT
)
(
    input  logic         clk,
    input  logic         rst_n,
    elc_text_if.sink     text,
    elc_result_if.source result,
    elc_cfg_if.sink      cfg
);

    localparam int CNT_W = $clog2(CHUNK_BYTES + 1);

    logic [63:0]                      charset_low_reg;
    logic [63:0]                      charset_high_reg;
    logic [elc_pkg::TH_W-1:0]         thresh_reg;
    logic [elc_pkg::BYTE_W-1:0]       marker_reg;

    logic [CNT_W-1:0]                 count_reg, count_next;
    logic [CNT_W-1:0]                 exam_reg, exam_next;
    logic [elc_pkg::BYTE_W-1:0]       prev_reg, prev_next;
    logic [elc_pkg::BYTE_W-1:0]       last_reg, last_next;
    logic                             allowed_reg, allowed_next;
    logic                             nul_reg, nul_next;

    logic                             out_valid_reg;
    logic [1:0]                       verdict_reg, verdict_next;
    logic [elc_pkg::VAL_W-1:0]        number_reg, number_next;
    logic [elc_pkg::VAL_W-1:0]        total_reg, total_next;
    logic [elc_pkg::LEN_W-1:0]        length_reg;

    logic [127:0]                     charset;
    logic [elc_pkg::BYTE_W-1:0]       c;
    logic                             accept;
    logic                             close;
    logic                             byte_ok;
    elc_pkg::match_ctl_t              mctl;
    elc_pkg::match_res_t              mres;

    assign c       = text.data_byte;
    assign charset = {charset_high_reg, charset_low_reg};
    assign byte_ok = !c[7] && charset[c[6:0]];

    assign text.ready = !out_valid_reg || result.ready;
    assign accept     = text.valid && text.ready;
    assign cfg.ready  = 1'b1;

    always_comb
    begin
        count_next   = count_reg + CNT_W'(1);
        nul_next     = nul_reg || (c == elc_pkg::CH_NUL);
        exam_next    = exam_reg;
        prev_next    = prev_reg;
        last_next    = last_reg;
        allowed_next = allowed_reg;
        if (!nul_next)
        begin
            exam_next    = exam_reg + CNT_W'(1);
            prev_next    = last_reg;
            last_next    = c;
            allowed_next = allowed_reg && byte_ok;
        end
        close = (c == elc_pkg::CH_NL) || (count_next >= CNT_W'(CHUNK_BYTES))
                || text.input_end;
    end

    assign mctl.take    = accept;
    assign mctl.examine = !nul_next;
    assign mctl.close   = close;

    elc_matcher u_matcher
    (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (mctl),
        .c     (c),
        .res   (mres)
    );

    always_comb
    begin
        verdict_next = elc_pkg::VERDICT_DROP;
        number_next  = '0;
        total_next   = '0;
        if (!allowed_next)
        begin
            if (mres.found)
            begin
                verdict_next = elc_pkg::VERDICT_HEADER;
                number_next  = mres.number;
                total_next   = mres.total;
            end
        end
        else if (exam_next >= CNT_W'(2) &&
                 (elc_pkg::TH_W'(exam_next) > thresh_reg || prev_next == marker_reg))
        begin
            verdict_next = elc_pkg::VERDICT_KEEP;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            charset_low_reg  <= elc_pkg::CHARSET_LOW_RESET;
            charset_high_reg <= elc_pkg::CHARSET_HIGH_RESET;
            thresh_reg       <= elc_pkg::LEN_THRESH_RESET;
            marker_reg       <= elc_pkg::END_MARKER_RESET;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.index)
                elc_pkg::CFG_CHARSET_LOW:  charset_low_reg  <= cfg.data;
                elc_pkg::CFG_CHARSET_HIGH: charset_high_reg <= cfg.data;
                elc_pkg::CFG_LEN_THRESH:   thresh_reg       <= cfg.data[elc_pkg::TH_W-1:0];
                elc_pkg::CFG_END_MARKER:   marker_reg       <= cfg.data[elc_pkg::BYTE_W-1:0];
                default:                   marker_reg       <= marker_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg   <= '0;
            exam_reg    <= '0;
            prev_reg    <= '0;
            last_reg    <= '0;
            allowed_reg <= 1'b1;
            nul_reg     <= 1'b0;
        end
        else if (accept)
        begin
            if (close)
            begin
                count_reg   <= '0;
                exam_reg    <= '0;
                prev_reg    <= '0;
                last_reg    <= '0;
                allowed_reg <= 1'b1;
                nul_reg     <= 1'b0;
            end
            else
            begin
                count_reg   <= count_next;
                exam_reg    <= exam_next;
                prev_reg    <= prev_next;
                last_reg    <= last_next;
                allowed_reg <= allowed_next;
                nul_reg     <= nul_next;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (accept && close)
            out_valid_reg <= 1'b1;
        else if (result.ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (accept && close)
        begin
            verdict_reg <= verdict_next;
            number_reg  <= number_next;
            total_reg   <= total_next;
            length_reg  <= elc_pkg::LEN_W'(exam_next);
        end
    end

    assign result.valid        = out_valid_reg;
    assign result.verdict      = verdict_reg;
    assign result.part_number  = number_reg;
    assign result.part_total   = total_reg;
    assign result.chunk_length = length_reg;

    `ELC_CHECK(a_stall_blocks_text, out_valid_reg && !result.ready, !text.ready, "text taken while result stalled")
    `ELC_INVARIANT(a_count_below_limit, count_reg < CNT_W'(CHUNK_BYTES), "chunk count reached limit without closing")
    `ELC_INVARIANT(a_exam_within_count, exam_reg <= count_reg, "examined bytes exceed chunk bytes")
    `ELC_CHECK(a_keep_needs_two, out_valid_reg && verdict_reg == elc_pkg::VERDICT_KEEP, length_reg >= elc_pkg::LEN_W'(2), "short chunk kept")
    `ELC_CHECK(a_numbers_only_header, out_valid_reg && verdict_reg != elc_pkg::VERDICT_HEADER, number_reg == '0 && total_reg == '0, "numbers without header")

endmodule

// File: bench/elc_verdict_check.sv
// Chunk verdict checker: tracks config writes, predicts each chunk result and compares it.
`timescale 1ns / 1ps

module elc_verdict_check
    import elc_pkg::*;
#(
    parameter int CHUNK_BYTES = CHUNK_BYTES_DEFAULT
)
(
    input  logic  clk,
    input  logic  rst_n,
    elc_text_if   text,
    elc_result_if result,
    elc_cfg_if    cfg,
    output int    mismatches,
    output int    open_results
);

    typedef enum logic [3:0] {
        HDR_IDLE,
        HDR_P,
        HDR_PA,
        HDR_PAR,
        HDR_PRE1,
        HDR_SIGN1,
        HDR_DIG1,
        HDR_WSOF,
        HDR_O,
        HDR_PRE2,
        HDR_SIGN2,
        HDR_DIG2,
        HDR_DONE
    } hdr_state_t;

    typedef struct packed {
        logic [1:0]         verdict;
        logic signed [31:0] number;
        logic signed [31:0] total;
        logic [LEN_W-1:0]   length;
    } chunk_verdict_t;

    logic [63:0]       allow_lo;
    logic [63:0]       allow_hi;
    logic [TH_W-1:0]   keep_len;
    logic [BYTE_W-1:0] keep_marker;

    logic [LEN_W-1:0]  taken;
    logic [LEN_W-1:0]  seen;
    logic [BYTE_W-1:0] prior_byte;
    logic [BYTE_W-1:0] newest_byte;
    logic              clean;
    logic              after_nul;
    hdr_state_t        scan;
    logic [31:0]       first_num;
    logic [31:0]       second_num;
    logic              num_neg;
    logic              hdr_found;

    chunk_verdict_t    verdict_q[$];
    int                errs;

    function automatic logic char_ok(input logic [BYTE_W-1:0] c);
        if (c[7])
            return 1'b0;
        return c[6] ? allow_hi[c[5:0]] : allow_lo[c[5:0]];
    endfunction

    function automatic logic blank_char(input logic [BYTE_W-1:0] c);
        return c == CH_SPACE || (c >= CH_TAB && c <= CH_CR);
    endfunction

    function automatic logic digit_char(input logic [BYTE_W-1:0] c);
        return c >= CH_ZERO && c <= CH_NINE;
    endfunction

    function automatic logic [31:0] push_digit(input logic [31:0] mag,
                                               input logic [BYTE_W-1:0] c);
        logic [39:0] v;
        v = 40'(mag) * 40'd10 + 40'(c - CH_ZERO);
        if (v > 40'h8000_0000)
            v = 40'h8000_0000;
        return v[31:0];
    endfunction

    function automatic logic [31:0] apply_sign(input logic [31:0] mag, input logic neg);
        if (neg)
            return 32'd0 - mag;
        return (mag > 32'h7FFF_FFFF) ? 32'h7FFF_FFFF : mag;
    endfunction

    task automatic clear_chunk();
        taken       = '0;
        seen        = '0;
        prior_byte  = '0;
        newest_byte = '0;
        clean       = 1'b1;
        after_nul   = 1'b0;
        scan        = HDR_IDLE;
        first_num   = '0;
        second_num  = '0;
        num_neg     = 1'b0;
        hdr_found   = 1'b0;
    endtask

    task automatic restart_scan(input logic [BYTE_W-1:0] c);
        scan       = (c == CH_P) ? HDR_P : HDR_IDLE;
        first_num  = '0;
        second_num = '0;
        num_neg    = 1'b0;
    endtask

    task automatic start_number(input logic [BYTE_W-1:0] c);
        if (!digit_char(c))
            restart_scan(c);
        else if (scan == HDR_PRE1 || scan == HDR_SIGN1)
        begin
            first_num = push_digit('0, c);
            scan      = HDR_DIG1;
        end
        else
        begin
            second_num = push_digit('0, c);
            scan       = HDR_DIG2;
            hdr_found  = 1'b1;
        end
    endtask

    task automatic scan_byte(input logic [BYTE_W-1:0] c);
        case (scan)
            HDR_IDLE:
                if (c == CH_P)
                    scan = HDR_P;
            HDR_P:
                if (c == CH_A) scan = HDR_PA; else restart_scan(c);
            HDR_PA:
                if (c == CH_R) scan = HDR_PAR; else restart_scan(c);
            HDR_PAR:
                if (c == CH_T) scan = HDR_PRE1; else restart_scan(c);
            HDR_PRE1, HDR_PRE2:
                if (!blank_char(c))
                begin
                    if (c == CH_PLUS || c == CH_MINUS)
                    begin
                        num_neg = (c == CH_MINUS);
                        scan    = (scan == HDR_PRE1) ? HDR_SIGN1 : HDR_SIGN2;
                    end
                    else
                        start_number(c);
                end
            HDR_SIGN1, HDR_SIGN2:
                start_number(c);
            HDR_DIG1:
                if (digit_char(c))
                    first_num = push_digit(first_num, c);
                else if (blank_char(c) || c == CH_O)
                begin
                    first_num = apply_sign(first_num, num_neg);
                    num_neg   = 1'b0;
                    scan      = (c == CH_O) ? HDR_O : HDR_WSOF;
                end
                else
                    restart_scan(c);
            HDR_WSOF:
                if (!blank_char(c))
                begin
                    if (c == CH_O) scan = HDR_O; else restart_scan(c);
                end
            HDR_O:
                if (c == CH_F) scan = HDR_PRE2; else restart_scan(c);
            HDR_DIG2:
                if (digit_char(c))
                    second_num = push_digit(second_num, c);
                else
                    scan = HDR_DONE;
            default:
                ;
        endcase
    endtask

    task automatic take_byte(input logic [BYTE_W-1:0] c, input logic last);
        chunk_verdict_t want;
        taken = taken + 1'b1;
        if (c == CH_NUL)
            after_nul = 1'b1;
        if (!after_nul)
        begin
            seen        = seen + 1'b1;
            prior_byte  = newest_byte;
            newest_byte = c;
            if (!char_ok(c))
                clean = 1'b0;
            if (!hdr_found || scan == HDR_DIG2)
                scan_byte(c);
        end
        if (c == CH_NL || taken >= CHUNK_BYTES || last)
        begin
            want.verdict = VERDICT_DROP;
            want.number  = '0;
            want.total   = '0;
            want.length  = seen;
            if (!clean)
            begin
                if (hdr_found)
                begin
                    want.verdict = VERDICT_HEADER;
                    want.number  = first_num;
                    want.total   = apply_sign(second_num, num_neg);
                end
            end
            else if (seen >= 2 && (seen > keep_len || prior_byte == keep_marker))
                want.verdict = VERDICT_KEEP;
            verdict_q.push_back(want);
            clear_chunk();
        end
    endtask

    task automatic note(input string what, input logic signed [63:0] want_v,
                        input logic signed [63:0] got_v);
        errs++;
        $display("%0t: %s expected %0d, got %0d", $time, what, want_v, got_v);
    endtask

    always @(posedge clk or negedge rst_n)
    begin : track
        chunk_verdict_t want;
        if (!rst_n)
        begin
            allow_lo    = CHARSET_LOW_RESET;
            allow_hi    = CHARSET_HIGH_RESET;
            keep_len    = LEN_THRESH_RESET;
            keep_marker = END_MARKER_RESET;
            clear_chunk();
            verdict_q.delete();
            errs = 0;
            mismatches   <= 0;
            open_results <= 0;
        end
        else
        begin
            if (cfg.valid && cfg.ready)
            begin
                case (cfg.index)
                    CFG_CHARSET_LOW:  allow_lo    = cfg.data;
                    CFG_CHARSET_HIGH: allow_hi    = cfg.data;
                    CFG_LEN_THRESH:   keep_len    = cfg.data[TH_W-1:0];
                    CFG_END_MARKER:   keep_marker = cfg.data[BYTE_W-1:0];
                    default:          ;
                endcase
            end
            if (text.valid && text.ready)
                take_byte(text.data_byte, text.input_end);
            if (result.valid && result.ready)
            begin
                if (verdict_q.size() == 0)
                begin
                    errs++;
                    $display("%0t: result with no chunk pending, expected none, got verdict %0d length %0d",
                             $time, result.verdict, result.chunk_length);
                end
                else
                begin
                    want = verdict_q.pop_front();
                    if (result.verdict !== want.verdict)
                        note("verdict", want.verdict, result.verdict);
                    if (result.part_number !== want.number)
                        note("part_number", want.number, result.part_number);
                    if (result.part_total !== want.total)
                        note("part_total", want.total, result.part_total);
                    if (result.chunk_length !== want.length)
                        note("chunk_length", want.length, result.chunk_length);
                end
            end
            mismatches   <= errs;
            open_results <= verdict_q.size();
        end
    end

endmodule

// File: bench/encoded_line_classifier_core_tb.sv
// Testbench top: clock, reset, text and config stimulus, result back-pressure and verdict.
`timescale 1ns / 1ps

module encoded_line_classifier_core_tb;
    import elc_pkg::*;

    localparam int CYCLE_LIMIT = 200000;
    localparam int PHASE_ITEMS = 160;
    localparam int LONG_HOLD   = 300;

    logic clk;
    logic rst_n;
    int   cycles = 0;
    int   send_idle_pct;
    int   recv_idle_pct;
    logic long_hold_req;
    int   mismatches;
    int   open_results;

    logic [63:0]       cs_lo;
    logic [63:0]       cs_hi;
    logic [BYTE_W-1:0] marker;
    logic [BYTE_W-1:0] line_q[$];

    elc_text_if   text_ch();
    elc_result_if result_ch();
    elc_cfg_if    cfg_ch();

    encoded_line_classifier_core u_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .text   (text_ch),
        .result (result_ch),
        .cfg    (cfg_ch)
    );

    elc_verdict_check u_verdict_check (
        .clk          (clk),
        .rst_n        (rst_n),
        .text         (text_ch),
        .result       (result_ch),
        .cfg          (cfg_ch),
        .mismatches   (mismatches),
        .open_results (open_results)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("encoded_line_classifier_core_tb: errors");
            $finish;
        end
    end

    initial
    begin : receiver
        logic held;
        held = 1'b0;
        result_ch.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (long_hold_req && !held)
            begin
                held = 1'b1;
                result_ch.ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
            end
            else
                result_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    function automatic logic char_ok(input logic [BYTE_W-1:0] c);
        if (c[7])
            return 1'b0;
        return c[6] ? cs_hi[c[5:0]] : cs_lo[c[5:0]];
    endfunction

    function automatic logic [BYTE_W-1:0] text_byte();
        logic [BYTE_W-1:0] b;
        repeat (16)
        begin
            b = 8'($urandom_range(1, 127));
            if (b != CH_NL && char_ok(b))
                return b;
        end
        return 8'($urandom_range(CH_A, CH_A + 25));
    endfunction

    task automatic push_text(input string s);
        foreach (s[i])
            line_q.push_back(s[i]);
    endtask

    task automatic push_blanks();
        int n;
        int r;
        n = $urandom_range(0, 2);
        repeat (n)
        begin
            r = $urandom_range(0, 4);
            line_q.push_back(r == 0 ? CH_SPACE : CH_TAB + 8'(r == 1 ? 0 : r));
        end
    endtask

    task automatic push_number();
        int r;
        int n;
        r = $urandom_range(0, 3);
        if (r == 1)
            line_q.push_back(CH_PLUS);
        else if (r == 2)
            line_q.push_back(CH_MINUS);
        r = $urandom_range(0, 9);
        case (r)
            0: push_text("2147483647");
            1: push_text("2147483648");
            2: push_text("99999999999");
            3: push_text("0");
            default:
            begin
                n = (r == 9) ? $urandom_range(7, 12) : $urandom_range(1, 6);
                repeat (n)
                    line_q.push_back(8'($urandom_range(CH_ZERO, CH_NINE)));
            end
        endcase
    endtask

    task automatic add_header();
        push_text("part");
        push_blanks();
        push_number();
        if ($urandom_range(3) != 0)
            push_blanks();
        push_text("of");
        push_blanks();
        push_number();
    endtask

    task automatic build_chunk(output logic end_flag);
        int kind;
        int n;
        kind = $urandom_range(99);
        end_flag = 1'b0;
        if (kind < 45)
        begin
            n = $urandom_range(0, 4);
            repeat (n) line_q.push_back(text_byte());
            if ($urandom_range(4) == 0)
                push_text("par");
            add_header();
            if ($urandom_range(4) == 0)
                add_header();
            n = $urandom_range(0, 5);
            repeat (n) line_q.push_back(text_byte());
            if (kind < 12)
                line_q[$urandom_range(line_q.size() - 1)] = 8'($urandom_range(32, 126));
            if ($urandom_range(1) == 1)
                line_q.insert($urandom_range(line_q.size()), 8'($urandom_range(128, 255)));
        end
        else if (kind < 70)
        begin
            n = $urandom_range(0, 90);
            repeat (n) line_q.push_back(text_byte());
            if ($urandom_range(1) == 1)
                line_q.push_back(marker);
        end
        else if (kind < 90)
        begin
            n = $urandom_range(1, 40);
            repeat (n) line_q.push_back(8'($urandom_range(0, 255)));
        end
        else
        begin
            n = $urandom_range(0, 12);
            repeat (n) line_q.push_back(text_byte());
            line_q.push_back(CH_NUL);
            n = $urandom_range(0, 12);
            repeat (n) line_q.push_back($urandom_range(1) ? text_byte() : 8'($urandom_range(128, 255)));
        end
        n = $urandom_range(99);
        if (n < 85)
            line_q.push_back(CH_NL);
        else if (n < 95)
        begin
            end_flag = 1'b1;
            if (line_q.size() == 0)
                line_q.push_back(text_byte());
        end
        else
        begin
            end_flag = 1'b1;
            line_q.push_back(CH_NL);
        end
    endtask

    task automatic send_byte(input logic [BYTE_W-1:0] c, input logic last);
        while ($urandom_range(99) < send_idle_pct)
        begin
            text_ch.valid <= 1'b0;
            @(posedge clk);
        end
        text_ch.valid     <= 1'b1;
        text_ch.data_byte <= c;
        text_ch.input_end <= last;
        @(posedge clk);
        while (!text_ch.ready)
            @(posedge clk);
    endtask

    task automatic send_line(input logic end_flag);
        foreach (line_q[i])
            send_byte(line_q[i], end_flag && i == line_q.size() - 1);
        line_q.delete();
    endtask

    task automatic settle();
        text_ch.valid <= 1'b0;
        @(posedge clk);
        while (open_results != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= val;
        @(posedge clk);
        while (!cfg_ch.ready)
            @(posedge clk);
    endtask

    task automatic configure(input logic [63:0] lo, input logic [63:0] hi,
                             input logic [TH_W-1:0] thr, input logic [BYTE_W-1:0] mark);
        write_reg(CFG_CHARSET_LOW, lo);
        write_reg(CFG_CHARSET_HIGH, hi);
        write_reg(CFG_LEN_THRESH, 64'(thr));
        write_reg(CFG_END_MARKER, 64'(mark));
        cfg_ch.valid <= 1'b0;
        cs_lo  = lo;
        cs_hi  = hi;
        marker = mark;
    endtask

    initial
    begin : stimulus
        int   sent;
        logic end_flag;
        rst_n             = 1'b0;
        text_ch.valid     = 1'b0;
        text_ch.data_byte = '0;
        text_ch.input_end = 1'b0;
        cfg_ch.valid      = 1'b0;
        cfg_ch.index      = CFG_CHARSET_LOW;
        cfg_ch.data       = '0;
        long_hold_req     = 1'b0;
        send_idle_pct     = 0;
        recv_idle_pct     = 0;
        cs_lo             = CHARSET_LOW_RESET;
        cs_hi             = CHARSET_HIGH_RESET;
        marker            = END_MARKER_RESET;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        push_text("part 3 of 12");
        line_q.push_back(8'hFF);
        line_q.push_back(CH_NL);
        send_line(1'b0);
        push_text("a:");
        line_q.push_back(CH_NL);
        send_line(1'b0);
        line_q.push_back(CH_NUL);
        line_q.push_back(CH_NL);
        send_line(1'b0);
        push_text("q");
        send_line(1'b1);

        for (int ph = 0; ph < 6; ph++)
        begin
            settle();
            case (ph)
                0: configure(CHARSET_LOW_RESET, CHARSET_HIGH_RESET, LEN_THRESH_RESET,
                             END_MARKER_RESET);
                1: configure({$urandom, $urandom}, {$urandom, $urandom},
                             13'($urandom_range(0, 80)), 8'($urandom_range(33, 126)));
                2: configure('1, '1, 13'd0, 8'hFF);
                3: configure('0, '0, 13'd4096, 8'h00);
                4: configure(CHARSET_LOW_RESET, CHARSET_HIGH_RESET,
                             13'($urandom_range(2, 30)), END_MARKER_RESET);
                default: configure({$urandom, $urandom} | CHARSET_LOW_RESET,
                                   {$urandom, $urandom} | CHARSET_HIGH_RESET,
                                   13'($urandom_range(40, 120)), 8'($urandom_range(33, 126)));
            endcase
            send_idle_pct = (ph < 2) ? 35 : (ph < 4) ? 88 : 0;
            recv_idle_pct <= (ph < 2) ? 88 : (ph < 4) ? 35 : 0;
            if (ph == 4)
                long_hold_req <= 1'b1;
            sent = 0;
            if (ph == 5)
            begin
                repeat (515) line_q.push_back(text_byte());
                line_q.push_back(CH_NL);
                sent = line_q.size();
                send_line(1'b0);
            end
            while (sent < PHASE_ITEMS)
            begin
                build_chunk(end_flag);
                sent += line_q.size();
                send_line(end_flag);
            end
        end

        settle();
        repeat (8) @(posedge clk);
        if (mismatches == 0 && open_results == 0)
            $display("encoded_line_classifier_core_tb: clean");
        else
            $display("encoded_line_classifier_core_tb: errors");
        $finish;
    end

endmodule

// File: sim.f
+incdir+design
design/elc_pkg.sv
design/elc_ifs.sv
design/elc_matcher.sv
design/encoded_line_classifier_core.sv
bench/elc_verdict_check.sv
bench/encoded_line_classifier_core_tb.sv
